FILE: sv/aopm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aopm_pkg: shared types and constants
// Widths, register indexes, sequencer states and helpers for the Asian option
// payoff mean core and its shared divider.
// ----------------------------------------------------------------------------
package aopm_pkg;

  localparam int PRICE_W    = 32;
  localparam int DISC_W     = 32;
  localparam int PROD_W     = PRICE_W + DISC_W;
  localparam int DISC_SHIFT = 31;
  localparam int PSUM_W     = 48;
  localparam int PCNT_W     = 17;
  localparam int BSUM_W     = 52;
  localparam int BCNT_W     = 21;

  // shared divider sizing: widest dividend and divisor of both uses
  localparam int DIVIDEND_W = BSUM_W;
  localparam int DIVISOR_W  = BCNT_W;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_PUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 2'd2;

  localparam logic [DISC_W-1:0] DISCOUNT_RESET = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MUL,
    ST_ACC,
    ST_EST,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // clamp a quotient to the 32-bit result range
  function automatic logic [PRICE_W-1:0] clamp_price(input logic [DIVIDEND_W-1:0] q);
    logic [PRICE_W-1:0] r;
    if (q[DIVIDEND_W-1:PRICE_W] != '0) begin
      r = '1;
    end else begin
      r = q[PRICE_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/aopm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aopm_if: stream channels of the payoff mean core
// Valid/ready channels for price samples in and path results out.
// ----------------------------------------------------------------------------
interface aopm_in_if;
  logic                         valid;
  logic                         ready;
  logic [aopm_pkg::PRICE_W-1:0] price_sample;
  logic                         last_of_path;
  logic                         last_of_batch;

  modport source (output valid, output price_sample, output last_of_path,
                  output last_of_batch, input ready);
  modport sink   (input valid, input price_sample, input last_of_path,
                  input last_of_batch, output ready);
endinterface

interface aopm_out_if;
  logic                         valid;
  logic                         ready;
  logic [aopm_pkg::PRICE_W-1:0] discounted_payoff;
  logic [aopm_pkg::PRICE_W-1:0] price_estimate;
  logic                         batch_done;

  modport source (output valid, output discounted_payoff, output price_estimate,
                  output batch_done, input ready);
  modport sink   (input valid, input discounted_payoff, input price_estimate,
                  input batch_done, output ready);
endinterface
`default_nettype wire

FILE: sv/aopm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aopm_div: shared restoring divider
// One quotient bit per cycle; used for the path mean and the batch estimate.
// A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module aopm_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [aopm_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [aopm_pkg::DIVISOR_W-1:0]    divisor,
  output aopm_pkg::div_stat_t                    stat,
  output logic [aopm_pkg::DIVIDEND_W-1:0]        quotient
);
  import aopm_pkg::*;

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  den_r;
  logic                  zero_r;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    rem_shift;
  logic                  q_bit;

  always_comb begin
    rem_shift = {rem_r, quo_r[DIVIDEND_W-1]};
    q_bit     = (rem_shift >= {1'b0, den_r});
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits the divisor width
      rem_nxt = q_bit ? DIVISOR_W'(rem_shift - {1'b0, den_r}) : rem_shift[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], q_bit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r  <= divisor;
      zero_r <= (divisor == '0);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = zero_r ? '0 : quo_r;

endmodule
`default_nettype wire

FILE: sv/asian_option_payoff_mean_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asian_option_payoff_mean_core: arithmetic-mean Asian option payoff back end
// Accumulates path samples, prices each finished path and averages the batch.
// ----------------------------------------------------------------------------
// A sample that does not end a path leaves the core idle and ready for the
// next sample. A path end runs the shared bit-serial divider for the path
// mean (ST_MEAN), then the 32x32 discount multiply (ST_MUL) and the
// accumulation (ST_ACC); when it also ends the batch, the divider runs again
// for the batch estimate (ST_EST). The output load (ST_EMIT) comes last.
// A result is held in an output register, so further samples are taken while
// it waits; the next path end then waits for the output register to drain.
// Configuration must be written only while idle; the core does not enforce it.
// ----------------------------------------------------------------------------
module asian_option_payoff_mean_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  aopm_in_if.sink                            in_stream,
  aopm_out_if.source                         out_stream,
  input  wire logic                          cfg_we,
  input  wire logic [aopm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aopm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import aopm_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [PRICE_W-1:0] strike_r;
  logic               is_put_r;
  logic [DISC_W-1:0]  discount_r;

  logic [PSUM_W-1:0]  path_sum_r, path_sum_nxt;
  logic [PCNT_W-1:0]  path_cnt_r, path_cnt_nxt;
  logic [BSUM_W-1:0]  pay_sum_r, pay_sum_nxt;
  logic [BCNT_W-1:0]  paths_r, paths_nxt;
  logic               batch_r, batch_nxt;

  logic [PRICE_W-1:0] diff_r, diff_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic [PRICE_W-1:0] payoff_r, payoff_nxt;
  logic [PRICE_W-1:0] est_r, est_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [PRICE_W-1:0] out_payoff_r;
  logic [PRICE_W-1:0] out_est_r;
  logic               out_batch_r;
  logic               out_load;

  logic               in_xfer;
  logic [PSUM_W:0]    psum_add;
  logic [PSUM_W-1:0]  psum_sat;
  logic [PCNT_W-1:0]  pcnt_sat;
  logic [BSUM_W:0]    bsum_add;
  logic [BSUM_W-1:0]  bsum_sat;
  logic [BCNT_W-1:0]  bcnt_sat;
  logic [PRICE_W-1:0] mean;
  logic [PRICE_W:0]   prod_hi;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  div_stat_t             div_st;
  logic [DIVIDEND_W-1:0] div_quo;

  aopm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_st),
    .quotient (div_quo)
  );

  assign in_stream.ready = (state_r == ST_IDLE);
  assign in_xfer         = in_stream.valid && in_stream.ready;

  // saturating accumulators
  always_comb begin
    psum_add = {1'b0, path_sum_r} + {{(PSUM_W + 1 - PRICE_W){1'b0}}, in_stream.price_sample};
    psum_sat = psum_add[PSUM_W] ? '1 : psum_add[PSUM_W-1:0];
    pcnt_sat = (path_cnt_r == '1) ? path_cnt_r : path_cnt_r + 1'b1;
    prod_hi  = prod_r[PROD_W-1:DISC_SHIFT];
    payoff_nxt = prod_hi[PRICE_W] ? '1 : prod_hi[PRICE_W-1:0];
    bsum_add = {1'b0, pay_sum_r} + {{(BSUM_W + 1 - PRICE_W){1'b0}}, payoff_nxt};
    bsum_sat = bsum_add[BSUM_W] ? '1 : bsum_add[BSUM_W-1:0];
    bcnt_sat = (paths_r == '1) ? paths_r : paths_r + 1'b1;
    mean     = clamp_price(div_quo);
  end

  always_comb begin
    state_nxt    = state_r;
    path_sum_nxt = path_sum_r;
    path_cnt_nxt = path_cnt_r;
    pay_sum_nxt  = pay_sum_r;
    paths_nxt    = paths_r;
    batch_nxt    = batch_r;
    diff_nxt     = diff_r;
    est_nxt      = est_r;
    div_start    = 1'b0;
    div_dividend = {{(DIVIDEND_W - PSUM_W){1'b0}}, psum_sat};
    div_divisor  = {{(DIVISOR_W - PCNT_W){1'b0}}, pcnt_sat};
    out_load     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_stream.last_of_path) begin
            // divider latches the updated path totals, so they clear now
            div_start    = 1'b1;
            path_sum_nxt = '0;
            path_cnt_nxt = '0;
            batch_nxt    = in_stream.last_of_batch;
            state_nxt    = ST_MEAN;
          end else begin
            path_sum_nxt = psum_sat;
            path_cnt_nxt = pcnt_sat;
          end
        end
      end
      ST_MEAN: begin
        if (div_st.done) begin
          if (is_put_r) begin
            diff_nxt = (strike_r > mean) ? strike_r - mean : '0;
          end else begin
            diff_nxt = (mean > strike_r) ? mean - strike_r : '0;
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        est_nxt = '0;
        if (batch_r) begin
          div_start    = 1'b1;
          div_dividend = bsum_sat;
          div_divisor  = bcnt_sat;
          pay_sum_nxt  = '0;
          paths_nxt    = '0;
          state_nxt    = ST_EST;
        end else begin
          pay_sum_nxt = bsum_sat;
          paths_nxt   = bcnt_sat;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EST: begin
        if (div_st.done) begin
          est_nxt   = mean;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_stream.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      path_sum_r  <= '0;
      path_cnt_r  <= '0;
      pay_sum_r   <= '0;
      paths_r     <= '0;
      batch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      path_sum_r  <= path_sum_nxt;
      path_cnt_r  <= path_cnt_nxt;
      pay_sum_r   <= pay_sum_nxt;
      paths_r     <= paths_nxt;
      batch_r     <= batch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strike_r   <= '0;
      is_put_r   <= 1'b0;
      discount_r <= DISCOUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STRIKE:   strike_r   <= cfg_wdata[PRICE_W-1:0];
        CFG_IS_PUT:   is_put_r   <= cfg_wdata[0];
        CFG_DISCOUNT: discount_r <= cfg_wdata[DISC_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    est_r  <= est_nxt;
    prod_r <= diff_r * discount_r;
    if (state_r == ST_ACC) begin
      payoff_r <= payoff_nxt;
    end
    if (out_load) begin
      out_payoff_r <= payoff_r;
      out_est_r    <= est_r;
      out_batch_r  <= batch_r;
    end
  end

  assign out_stream.valid             = out_valid_r;
  assign out_stream.discounted_payoff = out_payoff_r;
  assign out_stream.price_estimate    = out_est_r;
  assign out_stream.batch_done        = out_batch_r;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == ST_MEAN || state_r == ST_EST))
    else $error("divider finished outside a wait state");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into empty output register");

  a_sum_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (path_sum_r != '0) |-> (path_cnt_r != '0))
    else $error("path sum without samples");
`endif

endmodule
`default_nettype wire
